// ===== hw/rtl/ldf_pkg.sv =====
package ldf_pkg;

  // Width of the per-line content counter.
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REG_MAX_LEN = 2'd0,
    REG_STRIP   = 2'd1,
    REG_MODE    = 2'd2
  } ldf_reg_t;

  typedef enum logic [1:0] {
    MODE_ANY   = 2'd0,
    MODE_LF    = 2'd1,
    MODE_CRLF  = 2'd2,
    MODE_ALIAS = 2'd3
  } ldf_mode_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_len;
    logic             strip;
    logic [1:0]       mode;
  } ldf_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       frame_end;
    logic       too_long;
    logic       run_last;
  } ldf_res_t;

endpackage

// ===== hw/rtl/ldf_step.sv =====
module ldf_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  ldf_pkg::ldf_cfg_t cfg,
  output ldf_pkg::ldf_res_t res0,
  output ldf_pkg::ldf_res_t res1,
  output logic [1:0]        res_n
);
  import ldf_pkg::*;

  logic                   discard_r, discard_nxt;
  logic                   cr_pend_r, cr_pend_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  ldf_res_t         r0, r1, emit_v;
  logic [1:0]       n;
  logic             is_lf, is_cr, lf_ends, cr_holds;

  // Content byte overflows when count + 1 exceeds the limit in force, which is
  // the smaller of the register and the counter's full-scale value.
  function automatic logic over_limit(input logic [COUNT_WIDTH-1:0] cnt,
                                      input logic [LEN_W-1:0] lim);
    over_limit = (CMP_W'(cnt) >= CMP_W'(lim)) || (&cnt);
  endfunction

  always_comb begin
    discard_nxt = discard_r;
    cr_pend_nxt = cr_pend_r;
    count_nxt   = count_r;
    r0          = '0;
    r1          = '0;
    emit_v      = '0;
    n           = 2'd0;
    is_lf       = (byte_in == CH_LF);
    is_cr       = (byte_in == CH_CR);
    lf_ends     = is_lf && (cfg.mode != MODE_CRLF);
    cr_holds    = is_cr && (cfg.mode != MODE_LF);

    if (cr_pend_r && is_lf && (cfg.mode != MODE_LF)) begin
      // Held CR completes a CR LF delimiter.
      cr_pend_nxt = 1'b0;
      if (discard_r) begin
        discard_nxt = 1'b0;
      end else if (cfg.strip) begin
        r0 = '{data: 8'h00, byte_valid: 1'b0, frame_end: 1'b1, too_long: 1'b0,
               run_last: 1'b0};
        n  = 2'd1;
      end else begin
        r0 = '{data: CH_CR, byte_valid: 1'b1, frame_end: 1'b0, too_long: 1'b0,
               run_last: 1'b0};
        r1 = '{data: CH_LF, byte_valid: 1'b1, frame_end: 1'b1, too_long: 1'b0,
               run_last: 1'b0};
        n  = 2'd2;
      end
      count_nxt = '0;
    end else begin
      // A held CR that does not start a delimiter becomes content first.
      if (cr_pend_r) begin
        cr_pend_nxt = 1'b0;
        if (!discard_nxt) begin
          if (over_limit(count_nxt, cfg.max_len)) begin
            r0 = '{data: 8'h00, byte_valid: 1'b0, frame_end: 1'b0, too_long: 1'b1,
                   run_last: 1'b0};
            discard_nxt = 1'b1;
            count_nxt   = '0;
          end else begin
            r0 = '{data: CH_CR, byte_valid: 1'b1, frame_end: 1'b0, too_long: 1'b0,
                   run_last: 1'b0};
            count_nxt = count_nxt + COUNT_WIDTH'(1);
          end
          n = 2'd1;
        end
      end

      if (lf_ends) begin
        if (discard_nxt) begin
          discard_nxt = 1'b0;
        end else begin
          emit_v = '{data: cfg.strip ? 8'h00 : CH_LF, byte_valid: !cfg.strip,
                     frame_end: 1'b1, too_long: 1'b0, run_last: 1'b0};
          if (n == 2'd0) r0 = emit_v;
          else           r1 = emit_v;
          n = n + 2'd1;
        end
        count_nxt = '0;
      end else if (cr_holds) begin
        cr_pend_nxt = 1'b1;
      end else if (!discard_nxt) begin
        if (over_limit(count_nxt, cfg.max_len)) begin
          emit_v = '{data: 8'h00, byte_valid: 1'b0, frame_end: 1'b0, too_long: 1'b1,
                     run_last: 1'b0};
          discard_nxt = 1'b1;
          count_nxt   = '0;
        end else begin
          emit_v = '{data: byte_in, byte_valid: 1'b1, frame_end: 1'b0,
                     too_long: 1'b0, run_last: 1'b0};
          count_nxt = count_nxt + COUNT_WIDTH'(1);
        end
        if (n == 2'd0) r0 = emit_v;
        else           r1 = emit_v;
        n = n + 2'd1;
      end
    end

    if (n == 2'd1) r0.run_last = 1'b1;
    if (n == 2'd2) r1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_r <= 1'b0;
      cr_pend_r <= 1'b0;
      count_r   <= '0;
    end else if (fire) begin
      discard_r <= discard_nxt;
      cr_pend_r <= cr_pend_nxt;
      count_r   <= count_nxt;
    end
  end

  assign res0  = r0;
  assign res1  = r1;
  assign res_n = fire ? n : 2'd0;

endmodule

// ===== hw/rtl/ldf_res_queue.sv =====
module ldf_res_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ldf_pkg::ldf_res_t push0,
  input  ldf_pkg::ldf_res_t push1,
  input  logic [1:0]        push_n,
  output logic              room,
  output logic              deq_valid,
  input  logic              deq_ready,
  output ldf_pkg::ldf_res_t deq_data
);
  import ldf_pkg::*;

  ldf_res_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop;

  assign pop        = deq_valid && deq_ready;
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt  = count_r + QCNT_W'(push_n) - QCNT_W'(pop);

  // Room for the two results one byte can cause, judged on the stored count.
  assign room      = (count_r <= QCNT_W'(QDEPTH - 2));
  assign deq_valid = (count_r != '0);
  assign deq_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entry_r[wr_ptr_r] <= push0;
    if (push_n == 2'd2) entry_r[wr_ptr_r + QPTR_W'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/line_delimiter_framer.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_byte
// out     | out_valid / out_ready| out_byte, out_byte_valid, out_frame_end,
//         |                      | out_too_long, out_run_last
// cfg     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// A byte waits in the input register until the queue has room, then its results
// land in a four-entry result queue, and the first result shows from its head.
// One byte per cycle is taken while the queue holds at most two results, so a
// byte that yields two results needs two output transfers on a busy output.
// Synchronous active-low reset clears line state and restores register defaults.
// A stalled output fills the queue beyond two results and then drops in_ready.
module line_delimiter_framer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_byte_valid,
  output logic                      out_frame_end,
  output logic                      out_too_long,
  output logic                      out_run_last,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ldf_pkg::LEN_W-1:0] cfg_wdata
);
  import ldf_pkg::*;

  ldf_cfg_t   cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       room, fire;
  ldf_res_t   res0, res1, head;
  logic [1:0] res_n;

  assign fire     = s1_valid_r && room;
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len <= LEN_W'(1024);
      cfg_r.strip   <= 1'b1;
      cfg_r.mode    <= MODE_ANY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LEN: cfg_r.max_len <= cfg_wdata;
        REG_STRIP:   cfg_r.strip   <= cfg_wdata[0];
        REG_MODE:    cfg_r.mode    <= cfg_wdata[1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte_r <= in_byte;
  end

  ldf_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (s1_byte_r),
    .cfg     (cfg_r),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n)
  );

  ldf_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_n    (res_n),
    .room      (room),
    .deq_valid (out_valid),
    .deq_ready (out_ready),
    .deq_data  (head)
  );

  assign out_byte       = head.data;
  assign out_byte_valid = head.byte_valid;
  assign out_frame_end  = head.frame_end;
  assign out_too_long   = head.too_long;
  assign out_run_last   = head.run_last;

endmodule

// ===== hw/rtl/ldf_checker.sv =====
module ldf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_frame_end,
  input logic       out_too_long,
  input logic       out_run_last
);
  import ldf_pkg::*;

  // A stalled result transaction keeps its byte, frame-end and too-long fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_frame_end) && $stable(out_too_long))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00)
    else $error("result without a byte carries nonzero data");

  a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_long |-> !out_frame_end && !out_byte_valid && out_run_last)
    else $error("malformed too-long result");

  // A kept delimiter always closes with the LF byte.
  a_kept_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && out_byte_valid |-> out_byte == CH_LF)
    else $error("kept frame end is not LF");

endmodule

bind line_delimiter_framer ldf_checker u_ldf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_frame_end  (out_frame_end),
  .out_too_long   (out_too_long),
  .out_run_last   (out_run_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ldf_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_PCT = 33;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_byte_valid;
  logic out_frame_end;
  logic out_too_long;
  logic out_run_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MAX_LEN;
  logic [LEN_W-1:0] cfg_wdata = '0;

  line_delimiter_framer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_byte_valid(out_byte_valid),
    .out_frame_end(out_frame_end),
    .out_too_long(out_too_long),
    .out_run_last(out_run_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the registers and the line state.
  logic [LEN_W-1:0] lim_reg;
  logic strip_reg;
  ldf_mode_t mode_reg;
  logic discarding;
  logic [COUNT_WIDTH-1:0] line_count;
  logic cr_held;

  ldf_res_t step_out[$];
  ldf_res_t frame_results[$];

  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_aborts = 0;
  int n_writes = 0;
  int in_idle_pct = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               frame_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic report_mismatch(input string what);
    $display("Mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_result(input logic [7:0] d, input logic v, input logic e,
                            input logic t);
    ldf_res_t r;
    r.data = d;
    r.byte_valid = v;
    r.frame_end = e;
    r.too_long = t;
    r.run_last = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic take_content(input logic [7:0] b);
    longint unsigned cap;
    longint unsigned lim;
    cap = (64'd1 << COUNT_WIDTH) - 1;
    lim = (longint'(lim_reg) < cap) ? longint'(lim_reg) : cap;
    if (!discarding) begin
      if (longint'(line_count) + 1 > lim) begin
        add_result(8'h00, 1'b0, 1'b0, 1'b1);
        discarding = 1'b1;
        line_count = '0;
      end else begin
        line_count = line_count + 1'b1;
        add_result(b, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic end_line(input logic [7:0] last);
    if (discarding) begin
      discarding = 1'b0;
    end else if (strip_reg) begin
      add_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else begin
      add_result(last, 1'b1, 1'b1, 1'b0);
    end
    line_count = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (b == CH_LF && mode_reg != MODE_CRLF) begin
      end_line(CH_LF);
    end else if (b == CH_CR && mode_reg != MODE_LF) begin
      cr_held = 1'b1;
    end else begin
      take_content(b);
    end
  endtask

  // Works out the results one accepted byte causes and queues them.
  task automatic frame_byte(input logic [7:0] b);
    step_out.delete();
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CH_LF && mode_reg != MODE_LF) begin
        if (!discarding && !strip_reg) begin
          add_result(CH_CR, 1'b1, 1'b0, 1'b0);
          add_result(CH_LF, 1'b1, 1'b1, 1'b0);
          line_count = '0;
        end else begin
          end_line(CH_LF);
        end
      end else begin
        take_content(CH_CR);
        take_byte(b);
      end
    end else begin
      take_byte(b);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) frame_results.push_back(step_out[i]);
    n_items++;
  endtask

  task automatic check_result();
    ldf_res_t exp_r;
    if (frame_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h valid=%0b end=%0b",
                                out_byte, out_byte_valid, out_frame_end));
    end else begin
      exp_r = frame_results.pop_front();
      if (out_byte !== exp_r.data)
        report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_r.data));
      if (out_byte_valid !== exp_r.byte_valid)
        report_mismatch($sformatf("out_byte_valid %0b, expected %0b", out_byte_valid,
                                  exp_r.byte_valid));
      if (out_frame_end !== exp_r.frame_end)
        report_mismatch($sformatf("out_frame_end %0b, expected %0b", out_frame_end,
                                  exp_r.frame_end));
      if (out_too_long !== exp_r.too_long)
        report_mismatch($sformatf("out_too_long %0b, expected %0b", out_too_long,
                                  exp_r.too_long));
      if (out_run_last !== exp_r.run_last)
        report_mismatch($sformatf("out_run_last %0b, expected %0b", out_run_last,
                                  exp_r.run_last));
    end
    n_results++;
    if (out_frame_end === 1'b1) n_frames++;
    if (out_too_long === 1'b1) n_aborts++;
  endtask

  // All handshakes are sampled here, at the edge, with pre-edge values.
  always @(posedge clk) begin
    if (!rst_n) begin
      lim_reg = 16'd1024;
      strip_reg = 1'b1;
      mode_reg = MODE_ANY;
      discarding = 1'b0;
      line_count = '0;
      cr_held = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_LEN: lim_reg = cfg_wdata;
          REG_STRIP:   strip_reg = cfg_wdata[0];
          REG_MODE:    mode_reg = ldf_mode_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) frame_byte(in_byte);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Waits until every predicted result is out, then lets held bytes settle.
  // The first edge lets the predictor take the last accepted byte.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic test_reset_defaults();
    send_text("ab\nc\015\n\n\015x\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    settle();
  endtask

  task automatic test_kept_delimiter();
    write_reg(REG_STRIP, 16'h0000);
    send_text("a\015\n\n\015\015\n");
    settle();
  endtask

  task automatic test_terminator_modes();
    write_reg(REG_MODE, {14'h0000, MODE_LF});
    send_text("a\015\nb\n");
    settle();
    write_reg(REG_MODE, {14'h0000, MODE_CRLF});
    send_text("a\nb\015\n");
    settle();
    write_reg(REG_MODE, {14'h3FFF, MODE_ALIAS});
    send_text("\015\n\n");
    settle();
  endtask

  task automatic test_length_limit();
    write_reg(REG_STRIP, 16'hFFFF);
    write_reg(REG_MODE, {14'h0000, MODE_ANY});
    write_reg(REG_MAX_LEN, 16'd2);
    send_text("ab\nabc\nx\015\nab\015x\n");
    settle();
    write_reg(REG_MAX_LEN, 16'd0);
    send_text("a\n\n");
    settle();
    write_reg(REG_MAX_LEN, 16'd1);
    send_text("a\015b\n");
    settle();
  endtask

  task automatic test_register_index();
    // An out-of-range index must leave the limit of one untouched.
    write_reg(REG_UNUSED, 16'h0000);
    send_text("a\n");
    settle();
    // A held CR is resolved under the mode written after it.
    write_reg(REG_MAX_LEN, 16'hFFFF);
    send_text("\015");
    settle();
    write_reg(REG_MODE, {14'h0000, MODE_LF});
    send_text("\n");
    settle();
  endtask

  task automatic random_phase(input int n_lines, inout int sent);
    logic [LEN_W-1:0] lim;
    int len;
    int cap;
    case ($urandom_range(7))
      0: lim = 16'd0;
      1: lim = 16'd1;
      2: lim = 16'd2;
      3: lim = 16'd1024;
      4: lim = 16'hFFFF;
      5: lim = 16'($urandom_range(16'hFFFF));
      default: lim = 16'($urandom_range(3, 12));
    endcase
    write_reg(REG_MAX_LEN, lim);
    write_reg(REG_STRIP, {15'($urandom), 1'($urandom_range(1))});
    write_reg(REG_MODE, {14'($urandom), 2'($urandom_range(3))});
    cap = (lim > 12) ? 12 : int'(lim);
    repeat (n_lines) begin
      if ($urandom_range(99) < 10) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        len = $urandom_range(cap + 2);
        repeat (len) send_byte(8'($urandom));
        sent += len;
        case ($urandom_range(3))
          0: begin send_byte(CH_LF); sent += 1; end
          1: begin send_byte(CH_CR); send_byte(CH_LF); sent += 2; end
          2: begin send_byte(CH_CR); send_byte(8'($urandom)); sent += 2; end
          default: begin
            send_byte(CH_CR); send_byte(CH_CR); send_byte(CH_LF); sent += 3;
          end
        endcase
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int sent;
    sent = 0;
    // A long stretch with both sides always ready first.
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_phase(30, sent);
    random_phase(20, sent);
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    while (sent < RANDOM_ITEMS) random_phase(12, sent);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_kept_delimiter();
    test_terminator_modes();
    test_length_limit();
    test_register_index();
    test_random_traffic();
    settle();
    $display("Sent %0d bytes and checked %0d results (%0d line ends, %0d aborts).",
             n_items, n_results, n_frames, n_aborts);
    $display("Applied %0d register writes across limits, strip settings and modes.",
             n_writes);
    if (frame_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                frame_results.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
